>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/aemt_pkg.sv
// Package: shared constants, codes and types of the multiturn tracker.
package aemt_pkg;

    localparam int POSITION_BITS_DEF  = 10;
    localparam int FRAME_BITS_DEF     = 16;
    localparam int REV_COUNT_BITS_DEF = 24;

    localparam int THR_BITS       = 10;
    localparam int MPR_BITS       = 22;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 22;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [THR_BITS-1:0] WRAP_HIGH_RESET = 10'd900;
    localparam logic [THR_BITS-1:0] WRAP_LOW_RESET  = 10'd100;
    localparam logic [MPR_BITS-1:0] MPR_RESET       = 22'd65536;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_HIGH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_LOW  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MPR       = 2'd2;

    typedef enum logic [1:0] {
        WRAP_NONE = 2'd0,
        WRAP_FWD  = 2'd1,
        WRAP_BWD  = 2'd2
    } t_wrap;

    // Classification of one item, handed from front to back.
    typedef struct packed {
        t_wrap wrap;
        logic  first;
    } t_cls;

    typedef struct packed {
        logic [THR_BITS-1:0] high;
        logic [THR_BITS-1:0] low;
    } t_thr;

endpackage

>>> rtl/core/aemt_front.sv
// Front end: accepts frames, extracts position and classifies wrap crossings.
module aemt_front #(
    parameter int POSITION_BITS = aemt_pkg::POSITION_BITS_DEF,
    parameter int FRAME_BITS    = aemt_pkg::FRAME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [FRAME_BITS-1:0]    i_raw_frame,
    input  aemt_pkg::t_thr           i_thr,
    input  logic                     i_q_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output logic [POSITION_BITS-1:0] o_pos,
    output aemt_pkg::t_cls           o_cls
);

    localparam int CMP_W = (POSITION_BITS > aemt_pkg::THR_BITS) ?
                           POSITION_BITS : aemt_pkg::THR_BITS;

    logic                     r_taken;
    logic [POSITION_BITS-1:0] r_prev;
    logic [POSITION_BITS-1:0] pos;
    logic [CMP_W-1:0]         prev_c, pos_c, hi_c, lo_c;
    logic                     accept;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept;
    assign pos        = i_raw_frame[POSITION_BITS-1:0];
    assign o_pos      = pos;

    assign prev_c = CMP_W'(r_prev);
    assign pos_c  = CMP_W'(pos);
    assign hi_c   = CMP_W'(i_thr.high);
    assign lo_c   = CMP_W'(i_thr.low);

    // forward test has priority when both hold
    always_comb begin
        o_cls.first = 1'b0;
        o_cls.wrap  = aemt_pkg::WRAP_NONE;
        if (!r_taken) begin
            o_cls.first = 1'b1;
        end else if (prev_c >= hi_c && pos_c <= lo_c) begin
            o_cls.wrap = aemt_pkg::WRAP_FWD;
        end else if (prev_c <= lo_c && pos_c >= hi_c) begin
            o_cls.wrap = aemt_pkg::WRAP_BWD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
            r_prev  <= '0;
        end else if (accept) begin
            r_taken <= 1'b1;
            r_prev  <= pos;
        end
    end

endmodule

>>> rtl/core/aemt_queue.sv
// Small FIFO that decouples the front end from the back end.
module aemt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = aemt_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/aemt_back.sv
// Back end: revolution counter, total counts, distance multiply, output register.
module aemt_back #(
    parameter int POSITION_BITS  = aemt_pkg::POSITION_BITS_DEF,
    parameter int REV_COUNT_BITS = aemt_pkg::REV_COUNT_BITS_DEF,
    parameter int TOTAL_BITS     = REV_COUNT_BITS + POSITION_BITS + 1,
    parameter int DIST_BITS      = TOTAL_BITS + aemt_pkg::MPR_BITS - POSITION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  logic [POSITION_BITS-1:0]         i_pos,
    input  aemt_pkg::t_cls                   i_cls,
    input  logic [aemt_pkg::MPR_BITS-1:0]    i_mpr,
    input  logic                             i_out_stall,
    output logic                             o_pop,
    output logic                             o_out_valid,
    output logic [POSITION_BITS-1:0]         o_position,
    output logic [1:0]                       o_wrap_event,
    output logic signed [REV_COUNT_BITS-1:0] o_revolutions,
    output logic signed [TOTAL_BITS-1:0]     o_total_counts,
    output logic signed [DIST_BITS-1:0]      o_distance_q16
);

    localparam int PROD_BITS = TOTAL_BITS + aemt_pkg::MPR_BITS + 1;
    localparam logic [REV_COUNT_BITS-1:0] REV_MAX = {1'b0, {(REV_COUNT_BITS-1){1'b1}}};
    localparam logic [REV_COUNT_BITS-1:0] REV_MIN = {1'b1, {(REV_COUNT_BITS-1){1'b0}}};

    // counter state
    logic [REV_COUNT_BITS-1:0] r_rev, n_rev;
    logic [POSITION_BITS-1:0]  r_ref, ref_eff;
    logic [TOTAL_BITS-1:0]     rev_ext, n_total;

    // stage 1: counter and total
    logic                         r1_v;
    logic [POSITION_BITS-1:0]     r1_pos;
    aemt_pkg::t_wrap              r1_wrap;
    logic [REV_COUNT_BITS-1:0]    r1_rev;
    logic signed [TOTAL_BITS-1:0] r1_total;
    // stage 2: product
    logic                         r2_v;
    logic [POSITION_BITS-1:0]     r2_pos;
    aemt_pkg::t_wrap              r2_wrap;
    logic [REV_COUNT_BITS-1:0]    r2_rev;
    logic [TOTAL_BITS-1:0]        r2_total;
    logic signed [PROD_BITS-1:0]  r2_prod, prod;
    // stage 3: output register
    logic                         r3_v;

    logic adv1, adv2, adv3;

    assign adv3  = !r3_v || !i_out_stall;
    assign adv2  = !r2_v || adv3;
    assign adv1  = !r1_v || adv2;
    assign o_pop = i_q_valid && adv1;

    always_comb begin
        n_rev = r_rev;
        case (i_cls.wrap)
            aemt_pkg::WRAP_FWD: begin
                if (r_rev != REV_MAX) n_rev = r_rev + 1'b1;
            end
            aemt_pkg::WRAP_BWD: begin
                if (r_rev != REV_MIN) n_rev = r_rev - 1'b1;
            end
            default: n_rev = r_rev;
        endcase
    end

    // the first item is its own reference, so its total is zero
    assign ref_eff = i_cls.first ? i_pos : r_ref;
    assign rev_ext = TOTAL_BITS'($signed(n_rev));
    assign n_total = (rev_ext << POSITION_BITS) + TOTAL_BITS'(i_pos) - TOTAL_BITS'(ref_eff);

    assign prod = r1_total * $signed({1'b0, i_mpr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev <= '0;
            r_ref <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rev <= n_rev;
                if (i_cls.first) r_ref <= i_pos;
            end
            if (adv1) r1_v <= i_q_valid;
            if (adv2) r2_v <= r1_v;
            if (adv3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_pos   <= i_pos;
            r1_wrap  <= i_cls.wrap;
            r1_rev   <= n_rev;
            r1_total <= n_total;
        end
        if (adv2) begin
            r2_pos   <= r1_pos;
            r2_wrap  <= r1_wrap;
            r2_rev   <= r1_rev;
            r2_total <= r1_total;
            r2_prod  <= prod;
        end
        if (adv3) begin
            o_position     <= r2_pos;
            o_wrap_event   <= r2_wrap;
            o_revolutions  <= r2_rev;
            o_total_counts <= r2_total;
            // arithmetic shift by the position width floors toward minus infinity
            o_distance_q16 <= r2_prod[TOTAL_BITS+aemt_pkg::MPR_BITS-1:POSITION_BITS];
        end
    end

    assign o_out_valid = r3_v;

endmodule

>>> rtl/core/absolute_encoder_multiturn_tracker.sv
// Top level of the absolute encoder multiturn tracker.
// Each item is one shift-register frame whose low POSITION_BITS bits give the absolute
// single-turn position; the first frame after reset becomes the zero reference, and later
// frames count one revolution up or down when the position crosses from at or above the
// high threshold to at or below the low threshold (or back). Each frame yields one result:
// position, wrap event, saturating revolution count, total counts since the reference,
// and distance as total times metres-per-revolution (Q16) floored over 2^POSITION_BITS.
// One item is accepted per clock cycle unless the output stalls; a result passes from its
// item through the queue slot, counter stage, multiplier stage (the registered 35x23
// distance multiplier) and output register. Configuration registers are always ready.
module absolute_encoder_multiturn_tracker #(
    parameter int POSITION_BITS  = aemt_pkg::POSITION_BITS_DEF,
    parameter int FRAME_BITS     = aemt_pkg::FRAME_BITS_DEF,
    parameter int REV_COUNT_BITS = aemt_pkg::REV_COUNT_BITS_DEF,
    parameter int TOTAL_BITS     = REV_COUNT_BITS + POSITION_BITS + 1,
    parameter int DIST_BITS      = TOTAL_BITS + aemt_pkg::MPR_BITS - POSITION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [FRAME_BITS-1:0]               i_raw_frame,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [POSITION_BITS-1:0]            o_position,
    output logic [1:0]                          o_wrap_event,
    output logic signed [REV_COUNT_BITS-1:0]    o_revolutions,
    output logic signed [TOTAL_BITS-1:0]        o_total_counts,
    output logic signed [DIST_BITS-1:0]         o_distance_q16,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aemt_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [aemt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int Q_W = POSITION_BITS + $bits(aemt_pkg::t_cls);

    aemt_pkg::t_thr                r_thr;
    logic [aemt_pkg::MPR_BITS-1:0] r_mpr;

    logic                     push, pop, q_full, q_valid;
    logic [POSITION_BITS-1:0] f_pos, b_pos;
    aemt_pkg::t_cls           f_cls, b_cls;
    logic [Q_W-1:0]           q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.high <= aemt_pkg::WRAP_HIGH_RESET;
            r_thr.low  <= aemt_pkg::WRAP_LOW_RESET;
            r_mpr      <= aemt_pkg::MPR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aemt_pkg::CFG_WRAP_HIGH: r_thr.high <= i_cfg_data[aemt_pkg::THR_BITS-1:0];
                aemt_pkg::CFG_WRAP_LOW:  r_thr.low  <= i_cfg_data[aemt_pkg::THR_BITS-1:0];
                aemt_pkg::CFG_MPR:       r_mpr      <= i_cfg_data[aemt_pkg::MPR_BITS-1:0];
                default: ;
            endcase
        end
    end

    aemt_front #(
        .POSITION_BITS(POSITION_BITS),
        .FRAME_BITS   (FRAME_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_raw_frame(i_raw_frame),
        .i_thr      (r_thr),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_pos      (f_pos),
        .o_cls      (f_cls)
    );

    aemt_queue #(
        .WIDTH(Q_W),
        .DEPTH(aemt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_cls, f_pos}),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    assign b_pos = q_out[POSITION_BITS-1:0];
    assign b_cls = q_out[Q_W-1:POSITION_BITS];

    aemt_back #(
        .POSITION_BITS (POSITION_BITS),
        .REV_COUNT_BITS(REV_COUNT_BITS),
        .TOTAL_BITS    (TOTAL_BITS),
        .DIST_BITS     (DIST_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_pos         (b_pos),
        .i_cls         (b_cls),
        .i_mpr         (r_mpr),
        .i_out_stall   (i_out_stall),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_position    (o_position),
        .o_wrap_event  (o_wrap_event),
        .o_revolutions (o_revolutions),
        .o_total_counts(o_total_counts),
        .o_distance_q16(o_distance_q16)
    );

endmodule

>>> rtl/core/aemt_checker.sv
// Port-level checker for the multiturn tracker, with its bind.
`include "assert_macros.svh"

module aemt_checker #(
    parameter int POSITION_BITS  = aemt_pkg::POSITION_BITS_DEF,
    parameter int REV_COUNT_BITS = aemt_pkg::REV_COUNT_BITS_DEF,
    parameter int TOTAL_BITS     = REV_COUNT_BITS + POSITION_BITS + 1,
    parameter int DIST_BITS      = TOTAL_BITS + aemt_pkg::MPR_BITS - POSITION_BITS
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [POSITION_BITS-1:0]         o_position,
    input logic [1:0]                       o_wrap_event,
    input logic signed [REV_COUNT_BITS-1:0] o_revolutions,
    input logic signed [TOTAL_BITS-1:0]     o_total_counts,
    input logic signed [DIST_BITS-1:0]      o_distance_q16
);

    logic                      out_acc;
    logic                      r_seen;
    logic [REV_COUNT_BITS-1:0] r_last_rev;

    assign out_acc = o_out_valid && !i_out_stall;

    // revolution count of the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_rev <= '0;
        end else if (out_acc) begin
            r_seen     <= 1'b1;
            r_last_rev <= o_revolutions;
        end
    end

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
              o_out_valid && $stable(o_position) && $stable(o_wrap_event) &&
              $stable(o_total_counts) && $stable(o_revolutions) && $stable(o_distance_q16))
    `AST_IMPL(a_first_zero, i_clk, i_rst_n, o_out_valid && !r_seen,
              o_total_counts == '0 && o_revolutions == '0 &&
              o_wrap_event == 2'(aemt_pkg::WRAP_NONE))
    `AST_IMPL(a_no_wrap_keeps_rev, i_clk, i_rst_n,
              out_acc && r_seen && o_wrap_event == 2'(aemt_pkg::WRAP_NONE),
              o_revolutions == r_last_rev)
    `AST_IMPL(a_zero_total_zero_dist, i_clk, i_rst_n, o_out_valid && o_total_counts == '0,
              o_distance_q16 == '0)

endmodule

bind absolute_encoder_multiturn_tracker aemt_checker #(
    .POSITION_BITS (POSITION_BITS),
    .REV_COUNT_BITS(REV_COUNT_BITS),
    .TOTAL_BITS    (TOTAL_BITS),
    .DIST_BITS     (DIST_BITS)
) u_aemt_checker (.*);

>>> test/tb_absolute_encoder_multiturn_tracker.sv
// Testbench for the absolute encoder multiturn tracker: self-checking, random handshakes.
`timescale 1ns / 100ps

module tb_absolute_encoder_multiturn_tracker;

    localparam int POS_W   = aemt_pkg::POSITION_BITS_DEF;
    localparam int FRAME_W = aemt_pkg::FRAME_BITS_DEF;
    localparam int REV_W   = aemt_pkg::REV_COUNT_BITS_DEF;
    localparam int TOTAL_W = REV_W + POS_W + 1;
    localparam int DIST_W  = TOTAL_W + aemt_pkg::MPR_BITS - POS_W;
    localparam int IDX_W   = aemt_pkg::CFG_INDEX_BITS;
    localparam int DATA_W  = aemt_pkg::CFG_DATA_BITS;

    localparam logic [IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam longint REV_MAX       = (longint'(1) << (REV_W - 1)) - 1;
    localparam longint REV_MIN       = -REV_MAX - 1;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        aemt_pkg::t_wrap    wrap;
        logic [REV_W-1:0]   revs;
        logic [TOTAL_W-1:0] total;
        logic [DIST_W-1:0]  distance;
    } t_track_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [FRAME_W-1:0]        i_raw_frame = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [POS_W-1:0]          o_position;
    logic [1:0]                o_wrap_event;
    logic signed [REV_W-1:0]   o_revolutions;
    logic signed [TOTAL_W-1:0] o_total_counts;
    logic signed [DIST_W-1:0]  o_distance_q16;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [IDX_W-1:0]          i_cfg_index = '0;
    logic [DATA_W-1:0]         i_cfg_data = '0;

    // tracker shadow: configuration and state
    logic [aemt_pkg::THR_BITS-1:0] thr_high = aemt_pkg::WRAP_HIGH_RESET;
    logic [aemt_pkg::THR_BITS-1:0] thr_low  = aemt_pkg::WRAP_LOW_RESET;
    logic [aemt_pkg::MPR_BITS-1:0] mpr_q16  = aemt_pkg::MPR_RESET;
    logic [POS_W-1:0]              ref_pos  = '0;
    logic [POS_W-1:0]              last_pos = '0;
    longint                        revs_now = 0;
    logic                          have_ref = 1'b0;

    logic [FRAME_W-1:0] pending_frames[$];
    t_track_result      expected_tracks[$];
    logic [POS_W-1:0]   walk_pos = '0;
    logic               frame_taken = 1'b0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 cycle_count = 0;
    int                 mismatch_count = 0;
    int                 frames_sent = 0;
    int                 results_checked = 0;
    int                 fwd_seen = 0;
    int                 bwd_seen = 0;

    absolute_encoder_multiturn_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_frame    (i_raw_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position     (o_position),
        .o_wrap_event   (o_wrap_event),
        .o_revolutions  (o_revolutions),
        .o_total_counts (o_total_counts),
        .o_distance_q16 (o_distance_q16),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advances the shadow tracker by one frame and returns the result it should produce.
    function automatic t_track_result track_frame(logic [FRAME_W-1:0] frame);
        t_track_result r;
        logic [POS_W-1:0] pos;
        aemt_pkg::t_wrap ev;
        longint total;
        longint scaled;
        pos = frame[POS_W-1:0];
        ev = aemt_pkg::WRAP_NONE;
        if (!have_ref) begin
            have_ref = 1'b1;
            ref_pos = pos;
        end else if (last_pos >= thr_high && pos <= thr_low) begin
            // forward test wins when both hold
            ev = aemt_pkg::WRAP_FWD;
            if (revs_now < REV_MAX)
                revs_now++;
        end else if (last_pos <= thr_low && pos >= thr_high) begin
            ev = aemt_pkg::WRAP_BWD;
            if (revs_now > REV_MIN)
                revs_now--;
        end
        last_pos = pos;
        total = revs_now * (longint'(1) << POS_W) + longint'(pos) - longint'(ref_pos);
        // arithmetic shift gives the floor for negative distances
        scaled = (total * longint'(mpr_q16)) >>> POS_W;
        r.position = pos;
        r.wrap     = ev;
        r.revs     = revs_now[REV_W-1:0];
        r.total    = total[TOTAL_W-1:0];
        r.distance = scaled[DIST_W-1:0];
        return r;
    endfunction

    // Mostly a wandering shaft, with jumps onto thresholds and ends, and some noise.
    function automatic logic [FRAME_W-1:0] next_frame();
        logic [FRAME_W-1:0] frame;
        logic [POS_W-1:0] pos;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            pos = POS_W'(int'(walk_pos) + int'($urandom_range(400)) - 200);
        end else if (pick < 90) begin
            case ($urandom_range(5))
                0: pos = '0;
                1: pos = '1;
                2: pos = thr_high;
                3: pos = thr_low;
                4: pos = thr_high - 1'b1;
                default: pos = thr_low + 1'b1;
            endcase
        end else begin
            pos = POS_W'($urandom);
        end
        walk_pos = pos;
        frame = FRAME_W'($urandom);
        frame[POS_W-1:0] = pos;
        return frame;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                         name, results_checked, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_track_result want;
        t_track_result got;
        got.position = o_position;
        got.wrap     = aemt_pkg::t_wrap'(o_wrap_event);
        got.revs     = o_revolutions;
        got.total    = o_total_counts;
        got.distance = o_distance_q16;
        if (expected_tracks.size() == 0) begin
            if (mismatch_count < 10)
                $display("result with no item pending: position %0d", got.position);
            mismatch_count++;
        end else begin
            want = expected_tracks.pop_front();
            if (want.wrap == aemt_pkg::WRAP_FWD)
                fwd_seen++;
            else if (want.wrap == aemt_pkg::WRAP_BWD)
                bwd_seen++;
            check_field("position", want.position, got.position);
            check_field("wrap_event", want.wrap, got.wrap);
            check_field("revolutions", want.revs, got.revs);
            check_field("total_counts", want.total, got.total);
            check_field("distance_q16", want.distance, got.distance);
            results_checked++;
        end
    endtask

    // driver: frames and output stall change on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || frame_taken) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid  <= 1'b1;
                i_raw_frame <= pending_frames.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        frame_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    aemt_pkg::CFG_WRAP_HIGH: thr_high = i_cfg_data[aemt_pkg::THR_BITS-1:0];
                    aemt_pkg::CFG_WRAP_LOW:  thr_low  = i_cfg_data[aemt_pkg::THR_BITS-1:0];
                    aemt_pkg::CFG_MPR:       mpr_q16  = i_cfg_data[aemt_pkg::MPR_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                expected_tracks.push_back(track_frame(i_raw_frame));
                frames_sent++;
            end
            if (o_out_valid && !i_out_stall)
                check_result();
        end
    end

    task automatic write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_frames.size() != 0 || i_in_valid || expected_tracks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [DATA_W-1:0] high, logic [DATA_W-1:0] low,
                             logic [DATA_W-1:0] mpr, int send_idle, int recv_stall,
                             int n_items);
        write_register(aemt_pkg::CFG_WRAP_HIGH, high);
        write_register(aemt_pkg::CFG_WRAP_LOW, low);
        write_register(aemt_pkg::CFG_MPR, mpr);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (n_items) pending_frames.push_back(next_frame());
        drain();
    endtask

    initial begin
        logic [FRAME_W-1:0] directed[] = '{
            {6'h3F, 10'd500}, 16'd950, 16'd1023, 16'd0, 16'd100, 16'd950, 16'd900,
            16'd100, 16'd99, 16'd101, 16'd1000, 16'd0, 16'd1023, 16'd10, 16'd1000,
            16'd500, 16'd50, 16'd920, 16'd500, 16'd0, 16'hFFFF, 16'd512, 16'h0000
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: reference frame, wraps both ways, negative travel
        foreach (directed[k])
            pending_frames.push_back(directed[k]);
        walk_pos = '0;
        repeat (60) pending_frames.push_back(next_frame());
        drain();

        // upper data bits must be masked off; every frame satisfies both wrap tests
        run_phase(22'h3FFC00, 22'h3FFFFF, 22'h3FFFFF, 75, 0, 75);
        run_phase(22'd1023, 22'd0, 22'd0, 0, 75, 75);
        // high threshold below low threshold
        run_phase(22'd200, 22'd800, DATA_W'($urandom_range(4194303)), 25, 25, 75);
        write_register(CFG_SPARE_INDEX, DATA_W'($urandom));
        run_phase(22'd900, 22'd100, 22'd1, 0, 75, 75);
        run_phase(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), 75, 0, 75);

        $display("%0d frames sent, %0d results checked (%0d forward, %0d backward wraps)",
                 frames_sent, results_checked, fwd_seen, bwd_seen);
        $display("six register settings incl. extremes and inverted thresholds, four flow mixes");
        if (mismatch_count == 0 && expected_tracks.size() == 0) begin
            $display("absolute_encoder_multiturn_tracker regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_tracks.size());
            $display("absolute_encoder_multiturn_tracker regression: fail");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("absolute_encoder_multiturn_tracker regression: fail");
        $finish;
    end

endmodule

>>> absolute_encoder_multiturn_tracker.f
+incdir+rtl/core
rtl/core/aemt_pkg.sv
rtl/core/aemt_front.sv
rtl/core/aemt_queue.sv
rtl/core/aemt_back.sv
rtl/core/absolute_encoder_multiturn_tracker.sv
rtl/core/aemt_checker.sv
test/tb_absolute_encoder_multiturn_tracker.sv
